### design/sbpa_pkg.sv
package sbpa_pkg;

	localparam int SIZE_W          = 48;
	localparam int BKT_W           = 32;
	localparam int CNT_W           = 3;
	localparam int CFG_W           = 32;
	localparam int NUM_BUCKETS_DEF = 7;

	// register map
	localparam logic [CNT_W-1:0] REG_COUNT   = 3'd0;
	localparam logic [CNT_W-1:0] REG_BUCKET0 = 3'd1;

endpackage

### design/size_bucket_pad_amount.sv
// Bucket padding amount.
// Request channel: in_valid / in_ready with byte_size. A request is taken on a
// clock edge where both are high. Result channel: out_valid / out_ready with
// pad_bytes and zero_gap, one result per request, in request order.
// Configuration: cfg_we / cfg_idx / cfg_data, index 0 is the bucket count,
// indices 1..7 the bucket sizes (sorted ascending). Write only while idle.
// One request per cycle is sustained while results are taken. The remainder
// for the part above the last bucket comes from a restoring divider with
// one stage per bit of the
// 48-bit size offset, each stage one 33-bit compare and subtract. Two stages
// ahead of it compare against the buckets and pick the boundary.
// The whole pipeline advances when the result register is empty or taken.
// While the receiver stalls, one more request is still accepted into a skid
// register; in_ready drops only once that register is full.
// Reset clears the valid bits (the skid one too), the bucket count (padding
// off) and sets all bucket sizes to 1.
module size_bucket_pad_amount #(
	parameter int NUM_BUCKETS = sbpa_pkg::NUM_BUCKETS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [sbpa_pkg::CNT_W-1:0]  cfg_idx,
	input  logic [sbpa_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [sbpa_pkg::SIZE_W-1:0] byte_size,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [sbpa_pkg::BKT_W-1:0]  pad_bytes,
	output logic                        zero_gap
);
	import sbpa_pkg::*;

	localparam int DIV_N = SIZE_W;

	// configuration
	logic [CNT_W-1:0] count_q;
	logic [BKT_W-1:0] bucket_q [NUM_BUCKETS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we && cfg_idx == REG_COUNT) begin
			count_q <= cfg_data[CNT_W-1:0];
		end
	end

	for (genvar g = 0; g < NUM_BUCKETS; g++) begin : g_bkt
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				bucket_q[g] <= BKT_W'(1);
			end else if (cfg_we && cfg_idx == REG_BUCKET0 + CNT_W'(g)) begin
				bucket_q[g] <= cfg_data[BKT_W-1:0];
			end
		end
	end

	logic [CNT_W-1:0] n_eff;
	assign n_eff = (count_q > CNT_W'(NUM_BUCKETS)) ? CNT_W'(NUM_BUCKETS) : count_q;

	// pipeline control
	logic adv;
	logic vld_s3;
	assign adv = !vld_s3 || out_ready;

	// skid register
	logic              skid_vld_q;
	logic [SIZE_W-1:0] skid_size_q;
	logic              head_vld;
	logic [SIZE_W-1:0] head_size;

	assign in_ready  = !skid_vld_q;
	assign head_vld  = skid_vld_q || in_valid;
	assign head_size = skid_vld_q ? skid_size_q : byte_size;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (adv) begin
			skid_vld_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!adv && in_valid && in_ready) begin
			skid_size_q <= byte_size;
		end
	end

	// stage 1: compare size against every bucket
	logic                   vld_s1;
	logic [SIZE_W-1:0]      size_s1;
	logic [NUM_BUCKETS-1:0] lt_s1;
	logic [NUM_BUCKETS-1:0] gt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= head_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			size_s1 <= head_size;
			for (int i = 0; i < NUM_BUCKETS; i++) begin
				lt_s1[i] <= head_size < {(SIZE_W-BKT_W)'(0), bucket_q[i]};
				gt_s1[i] <= head_size > {(SIZE_W-BKT_W)'(0), bucket_q[i]};
			end
		end
	end

	// stage 2: pick the boundary, or set up the extrapolation
	logic              hit;
	logic [BKT_W-1:0]  hi_bkt;
	logic [BKT_W-1:0]  last_bkt;
	logic [BKT_W-1:0]  prev_bkt;
	logic              gt_last;
	logic              ext;
	logic [CNT_W-1:0]  n_m1;
	logic [CNT_W-1:0]  n_m2;

	always_comb begin
		hit      = 1'b0;
		hi_bkt   = '0;
		last_bkt = '0;
		prev_bkt = '0;
		gt_last  = 1'b0;
		n_m1     = n_eff - CNT_W'(1);
		n_m2     = n_eff - CNT_W'(2);
		if (n_eff != '0 && lt_s1[0]) begin
			hit    = 1'b1;
			hi_bkt = bucket_q[0];
		end
		for (int i = 0; i + 1 < NUM_BUCKETS; i++) begin
			if (!hit && CNT_W'(i + 1) < n_eff && gt_s1[i] && lt_s1[i+1]) begin
				hit    = 1'b1;
				hi_bkt = bucket_q[i+1];
			end
		end
		for (int i = 0; i < NUM_BUCKETS; i++) begin
			if (n_m1 == CNT_W'(i)) begin
				last_bkt = bucket_q[i];
				gt_last  = gt_s1[i];
			end
			if (n_m2 == CNT_W'(i)) begin
				prev_bkt = bucket_q[i];
			end
		end
		ext = !hit && n_eff > CNT_W'(1) && gt_last;
	end

	// divider stage arrays; index 0 is stage 2
	logic              div_vld_sd [DIV_N+1];
	logic              div_ext_sd [DIV_N+1];
	logic [BKT_W-1:0]  div_pad_sd [DIV_N+1];
	logic [BKT_W-1:0]  div_gap_sd [DIV_N+1];
	logic [BKT_W-1:0]  div_rem_sd [DIV_N+1];
	logic [SIZE_W-1:0] div_dd_sd  [DIV_N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_sd[0] <= 1'b0;
		end else if (adv) begin
			div_vld_sd[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_ext_sd[0] <= ext;
			div_pad_sd[0] <= hit ? hi_bkt - size_s1[BKT_W-1:0] : '0;
			div_gap_sd[0] <= last_bkt - prev_bkt;
			div_rem_sd[0] <= '0;
			div_dd_sd[0]  <= size_s1 - {(SIZE_W-BKT_W)'(0), last_bkt};
		end
	end

	// restoring remainder, one dividend bit per stage, MSB first
	for (genvar k = 0; k < DIV_N; k++) begin : g_div
		logic [BKT_W:0] trial;
		logic [BKT_W:0] diff;

		assign trial = {div_rem_sd[k], div_dd_sd[k][SIZE_W-1]};
		assign diff  = trial - {1'b0, div_gap_sd[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_sd[k+1] <= 1'b0;
			end else if (adv) begin
				div_vld_sd[k+1] <= div_vld_sd[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_ext_sd[k+1] <= div_ext_sd[k];
				div_pad_sd[k+1] <= div_pad_sd[k];
				div_gap_sd[k+1] <= div_gap_sd[k];
				div_dd_sd[k+1]  <= {div_dd_sd[k][SIZE_W-2:0], 1'b0};
				div_rem_sd[k+1] <= (trial >= {1'b0, div_gap_sd[k]}) ?
					diff[BKT_W-1:0] : trial[BKT_W-1:0];
			end
		end
	end

	// output register
	logic              fin_ext;
	logic [BKT_W-1:0]  fin_gap;
	logic [BKT_W-1:0]  fin_rem;
	logic [BKT_W-1:0]  pad_s3;
	logic              flag_s3;

	assign fin_ext = div_ext_sd[DIV_N];
	assign fin_gap = div_gap_sd[DIV_N];
	assign fin_rem = div_rem_sd[DIV_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= div_vld_sd[DIV_N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flag_s3 <= fin_ext && fin_gap == '0;
			if (!fin_ext) begin
				pad_s3 <= div_pad_sd[DIV_N];
			end else if (fin_gap == '0 || fin_rem == '0) begin
				pad_s3 <= '0;
			end else begin
				pad_s3 <= fin_gap - fin_rem;
			end
		end
	end

	assign out_valid = vld_s3;
	assign pad_bytes = pad_s3;
	assign zero_gap  = flag_s3;

endmodule

### design/sbpa_chk.sv
module sbpa_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [sbpa_pkg::BKT_W-1:0] pad_bytes,
	input logic                       zero_gap
);
	import sbpa_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pad_bytes) && $stable(zero_gap))
		else $error("result changed while stalled");

	// zero gap never comes with padding
	a_flag_pad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_gap |-> pad_bytes == '0)
		else $error("zero_gap with nonzero pad");

	// skid fills only when the result side is stalled
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(out_valid && !out_ready && in_valid))
		else $error("in_ready dropped without a stall");

	// skid drains only when the pipeline advances
	a_ready_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> $past(!out_valid || out_ready))
		else $error("in_ready rose during a stall");

endmodule

bind size_bucket_pad_amount sbpa_chk u_sbpa_chk (.*);
